// ----- sv/wahp_pkg.sv -----
// Shared types, codes and helpers for the WAVE/AIFF header parser.
`timescale 1ns / 1ps
package wahp_pkg;
	localparam int DivW = 32;

	localparam logic [3:0] PH_SIG   = 4'd0;
	localparam logic [3:0] PH_FSIZE = 4'd1;
	localparam logic [3:0] PH_FTYPE = 4'd2;
	localparam logic [3:0] PH_CID   = 4'd3;
	localparam logic [3:0] PH_CSIZE = 4'd4;
	localparam logic [3:0] PH_FMT   = 4'd5;
	localparam logic [3:0] PH_XLEN  = 4'd6;
	localparam logic [3:0] PH_COMM  = 4'd7;
	localparam logic [3:0] PH_SKIP  = 4'd8;
	localparam logic [3:0] PH_DONE  = 4'd9;
	localparam logic [3:0] PH_DIV   = 4'd10;
	localparam logic [3:0] PH_OUT   = 4'd11;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FORM = 32'h464F524D;
	localparam logic [31:0] TAG_AIFF = 32'h41494646;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
	localparam logic [31:0] TAG_SSND = 32'h53534E44;
	localparam logic [31:0] RATE_11K = 32'h400CAC44;
	localparam logic [31:0] RATE_22K = 32'h400DAC44;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SIG   = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_EARLY = 2'd3;

	// datapath commands from the controller
	typedef struct packed {
		logic       clear;      // reset all captured state
		logic       shift;      // shift in a byte
		logic       big;        // big-endian shift
		logic       set_aiff;
		logic       aiff_val;
		logic       cap_fsize;
		logic       cap_tag;    // chunk tag latch
		logic [4:0] fmt_idx;    // fmt/COMM capture point, 0 none
		logic       comm;       // COMM capture (else fmt)
		logic       load_skip;
		logic       load_xskip;
		logic       dec_skip;
		logic       cap_dsize;
		logic       div_start;
	} wahp_cmd_t;

	typedef struct packed {
		logic [31:0] word;       // assembly word after the shift this byte
		logic [31:0] chunk_tag;
		logic        is_aiff;
		logic [15:0] fmt_tag;
		logic [15:0] align;
		logic        skip_last;  // skip counter at one or zero
		logic        div_done;
	} wahp_sts_t;

	function automatic logic [2:0] width_code(input logic [15:0] bits);
		if (bits <= 16'd8) return 3'd1;
		if (bits <= 16'd16) return 3'd2;
		if (bits <= 16'd24) return 3'd3;
		if (bits <= 16'd32) return 3'd4;
		return 3'd0;
	endfunction
endpackage

// ----- sv/wahp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wahp_div import wahp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] dividend,
	input  logic [15:0]     divisor,
	output logic            done,
	output logic [DivW-1:0] quotient
);
	localparam int CntW = $clog2(DivW + 1);
	logic [DivW-1:0] q_q;
	logic [16:0]     rem_q;
	logic [15:0]     dvs_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [16:0]     trial;

	assign trial = {rem_q[15:0], q_q[DivW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// pulse once the last quotient bit has landed in q_q
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				q_q   <= {q_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule

// ----- sv/wahp_datapath.sv -----
// Byte assembly, captured header fields, skip counter and divider.
`timescale 1ns / 1ps
module wahp_datapath import wahp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  wahp_cmd_t   cmd,
	output wahp_sts_t   sts,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] bits_per_sample,
	output logic [2:0]  sample_format,
	output logic [31:0] file_size,
	output logic [31:0] data_size,
	output logic [31:0] sample_count
);
	logic [31:0] word_q, tag_q, skip_q, nxt;
	logic        aiff_q;
	logic [15:0] half;
	logic        div_done;
	logic [31:0] quot;

	assign nxt  = !cmd.shift ? word_q :
		cmd.big ? {word_q[23:0], data_byte} : {data_byte, word_q[31:8]};
	assign half = aiff_q ? nxt[15:0] : nxt[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0; tag_q <= '0; skip_q <= '0; aiff_q <= 1'b0;
			format_tag <= '0; channel_count <= '0; sample_rate <= '0;
			byte_rate <= '0; block_align <= '0; bits_per_sample <= '0;
			sample_format <= '0; file_size <= '0; data_size <= '0;
			sample_count <= '0;
		end else if (cmd.clear) begin
			word_q <= '0; tag_q <= '0; skip_q <= '0; aiff_q <= 1'b0;
			format_tag <= '0; channel_count <= '0; sample_rate <= '0;
			byte_rate <= '0; block_align <= '0; bits_per_sample <= '0;
			sample_format <= '0; file_size <= '0; data_size <= '0;
			sample_count <= '0;
		end else begin
			word_q <= nxt;
			if (cmd.set_aiff)  aiff_q <= cmd.aiff_val;
			if (cmd.cap_fsize) file_size <= nxt;
			if (cmd.cap_tag)   tag_q <= nxt;
			if (cmd.load_skip) skip_q <= nxt;
			else if (cmd.load_xskip) skip_q <= {16'd0, nxt[31:16]};
			else if (cmd.dec_skip && skip_q != 32'd0) skip_q <= skip_q - 1'b1;
			if (cmd.cap_dsize) data_size <= nxt;
			if (div_done) sample_count <= quot;
			if (cmd.comm) begin
				case (cmd.fmt_idx)
					5'd2: channel_count <= half;
					5'd6: sample_count <= nxt;
					5'd8: begin
						bits_per_sample <= half;
						sample_format   <= width_code(half);
					end
					5'd12: sample_rate <= (nxt == RATE_11K) ? 32'd11025 :
						(nxt == RATE_22K) ? 32'd22050 : 32'd44100;
					default: ;
				endcase
			end else begin
				case (cmd.fmt_idx)
					5'd2:  format_tag <= nxt[31:16];
					5'd4:  channel_count <= nxt[31:16];
					5'd8:  sample_rate <= nxt;
					5'd12: byte_rate <= nxt;
					5'd14: block_align <= nxt[31:16];
					5'd16: begin
						bits_per_sample <= nxt[31:16];
						sample_format   <= width_code(nxt[31:16]);
					end
					default: ;
				endcase
			end
		end
	end

	wahp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(nxt), .divisor(block_align),
		.done(div_done), .quotient(quot)
	);

	assign sts.word      = nxt;
	assign sts.chunk_tag = tag_q;
	assign sts.is_aiff   = aiff_q;
	assign sts.fmt_tag   = format_tag;
	assign sts.align     = block_align;
	assign sts.skip_last = (skip_q <= 32'd1);
	assign sts.div_done  = div_done;
endmodule

// ----- sv/wahp_ctrl.sv -----
// Phase controller of the header parser.
`timescale 1ns / 1ps
module wahp_ctrl import wahp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      eos,
	input  logic      out_ready,
	input  wahp_sts_t sts,
	output wahp_cmd_t cmd,
	output logic      in_ready,
	output logic      out_valid,
	output logic [1:0] out_status,
	output logic      out_err
);
	logic [3:0] ph_q, ph_d;
	logic [4:0] idx_q, idx_d, inc;
	logic       busy_q, busy_d, err_q, err_d;
	logic [1:0] st_q, st_d;
	logic       cont_q, cont_d;

	assign inc = idx_q + 5'd1;
	assign in_ready = !busy_q;

	always_comb begin
		cmd = '0;
		ph_d = ph_q; idx_d = idx_q; busy_d = busy_q; err_d = err_q;
		st_d = st_q; cont_d = cont_q;
		if (busy_q) begin
			if (ph_q == PH_DIV) begin
				if (sts.div_done) ph_d = PH_OUT;
			end else if (ph_q == PH_OUT && out_ready) begin
				busy_d = 1'b0;
				if (cont_q) begin
					ph_d = PH_SIG; cmd.clear = 1'b1;
				end else begin
					ph_d = PH_DONE;
				end
			end
		end else if (in_fire) begin
			if (eos) begin
				idx_d = '0; ph_d = PH_SIG;
				if (ph_q == PH_DONE) begin
					cmd.clear = 1'b1;
				end else begin
					busy_d = 1'b1; err_d = 1'b1; st_d = ST_EARLY;
					cont_d = 1'b1; ph_d = PH_OUT;
				end
			end else if (ph_q != PH_DONE) begin
				idx_d = inc;
				cmd.shift = 1'b1;
				cmd.big = (ph_q == PH_SIG || ph_q == PH_FTYPE || ph_q == PH_CID ||
					ph_q == PH_COMM) ? 1'b1 :
					(ph_q == PH_FSIZE || ph_q == PH_CSIZE) ? sts.is_aiff : 1'b0;
				case (ph_q)
					PH_SIG: if (inc == 5'd4) begin
						idx_d = '0;
						if (sts.word == TAG_RIFF || sts.word == TAG_FORM) begin
							cmd.set_aiff = 1'b1;
							cmd.aiff_val = (sts.word == TAG_FORM);
							ph_d = PH_FSIZE;
						end else begin
							busy_d = 1'b1; err_d = 1'b1; st_d = ST_SIG;
							cont_d = 1'b0; ph_d = PH_OUT;
						end
					end
					PH_FSIZE: if (inc == 5'd4) begin
						idx_d = '0;
						if (sts.word == 32'd0) begin
							busy_d = 1'b1; err_d = 1'b1; st_d = ST_ZERO;
							cont_d = 1'b0; ph_d = PH_OUT;
						end else begin
							cmd.cap_fsize = 1'b1; ph_d = PH_FTYPE;
						end
					end
					PH_FTYPE: if (inc == 5'd4) begin
						idx_d = '0;
						if (sts.word != (sts.is_aiff ? TAG_AIFF : TAG_WAVE)) begin
							busy_d = 1'b1; err_d = 1'b1; st_d = ST_SIG;
							cont_d = 1'b0; ph_d = PH_OUT;
						end else begin
							ph_d = PH_CID;
						end
					end
					PH_CID: if (inc == 5'd4) begin
						idx_d = '0; cmd.cap_tag = 1'b1; ph_d = PH_CSIZE;
					end
					PH_CSIZE: if (inc == 5'd4) begin
						idx_d = '0;
						if (sts.word == 32'd0) begin
							busy_d = 1'b1; err_d = 1'b1; st_d = ST_ZERO;
							cont_d = 1'b0; ph_d = PH_OUT;
						end else if (!sts.is_aiff && sts.chunk_tag == TAG_FMT) begin
							ph_d = PH_FMT;
						end else if (!sts.is_aiff && sts.chunk_tag == TAG_DATA) begin
							cmd.cap_dsize = 1'b1;
							busy_d = 1'b1; err_d = 1'b0; st_d = ST_OK; cont_d = 1'b0;
							if (sts.align == 16'd0) begin
								ph_d = PH_OUT;
							end else begin
								cmd.div_start = 1'b1; ph_d = PH_DIV;
							end
						end else if (sts.is_aiff && sts.chunk_tag == TAG_COMM) begin
							ph_d = PH_COMM;
						end else if (sts.is_aiff && sts.chunk_tag == TAG_SSND) begin
							cmd.cap_dsize = 1'b1;
							busy_d = 1'b1; err_d = 1'b0; st_d = ST_OK; cont_d = 1'b0;
							ph_d = PH_OUT;
						end else begin
							cmd.load_skip = 1'b1; ph_d = PH_SKIP;
						end
					end
					PH_FMT: begin
						cmd.fmt_idx = inc;
						if (inc == 5'd16) begin
							idx_d = '0;
							ph_d = (sts.fmt_tag != 16'd1) ? PH_XLEN : PH_CID;
						end
					end
					PH_XLEN: if (inc == 5'd2) begin
						idx_d = '0;
						if (sts.word[31:16] == 16'd0) begin
							ph_d = PH_CID;
						end else begin
							cmd.load_xskip = 1'b1; ph_d = PH_SKIP;
						end
					end
					PH_COMM: begin
						cmd.comm = 1'b1;
						cmd.fmt_idx = inc;
						if (inc == 5'd18) begin
							idx_d = '0; ph_d = PH_CID;
						end
					end
					PH_SKIP: begin
						cmd.shift = 1'b0;
						cmd.dec_skip = 1'b1;
						if (sts.skip_last) begin
							idx_d = '0; ph_d = PH_CID;
						end
					end
					default: begin
						cmd.clear = 1'b1; ph_d = PH_SIG; idx_d = '0;
					end
				endcase
			end
		end
		// error results report zeros through the top-level mask; payload is cleared on take only after an early end of stream
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_SIG; idx_q <= '0; busy_q <= 1'b0; err_q <= 1'b0;
			st_q <= ST_OK; cont_q <= 1'b0;
		end else begin
			ph_q <= ph_d; idx_q <= idx_d; busy_q <= busy_d; err_q <= err_d;
			st_q <= st_d; cont_q <= cont_d;
		end
	end

	assign out_valid  = busy_q && (ph_q == PH_OUT);
	assign out_status = st_q;
	assign out_err    = err_q;

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_div_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DIV) |-> (busy_q && !err_q)) else $error("divide outside ok path");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// ----- sv/wav_aiff_header_parser.sv -----
// Top level of the RIFF/WAVE and FORM/AIFF header parser.
`timescale 1ns / 1ps
// Takes a file one byte per word and walks the container header; when the
// data/SSND chunk is reached, or on any fault, one result word is offered.
// Bytes are taken one per cycle while no divide or result is pending; a WAVE data
// chunk with nonzero block align first runs the one-bit-per-cycle sample-count
// divider (32 steps, then a done pulse hands over the quotient), and the result then
// waits in the output stage until taken, with input stalled.
// After a result, bytes are dropped until a word with the end-of-stream flag.
// An end-of-stream word before a result gives status 3 and re-arms.
// Error results carry zero in every field but status and container.
module wav_aiff_header_parser import wahp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // end_of_stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [1:0] status, [2] container, [18:3] format_tag, [34:19] channel_count,
	// [66:35] sample_rate, [98:67] byte_rate, [114:99] block_align,
	// [130:115] bits_per_sample, [133:131] sample_format, [165:134] file_size,
	// [197:166] data_size, [229:198] sample_count, [231:230] zero
	output logic [231:0] m_tdata
);
	wahp_cmd_t   cmd;
	wahp_sts_t   sts;
	logic [1:0]  st;
	logic        err;
	logic [15:0] ftag, chan, align, bits;
	logic [31:0] rate, brate, fsize, dsize, cnt;
	logic [2:0]  sfmt;

	wahp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.eos(s_tlast), .out_ready(m_tready), .sts(sts), .cmd(cmd),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_status(st), .out_err(err)
	);

	wahp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(s_tdata), .cmd(cmd), .sts(sts),
		.format_tag(ftag), .channel_count(chan), .sample_rate(rate),
		.byte_rate(brate), .block_align(align), .bits_per_sample(bits),
		.sample_format(sfmt), .file_size(fsize), .data_size(dsize),
		.sample_count(cnt)
	);

	// error words mask all captured fields
	assign m_tdata = err ? {2'b00, 227'd0, sts.is_aiff, st} :
		{2'b00, cnt, dsize, fsize, sfmt, bits, align, brate, rate, chan, ftag,
		sts.is_aiff, st};
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the WAVE/AIFF header parser: directed headers, a backpressure run and random streams.
`timescale 1ns / 1ps
module tb_top;
	import wahp_pkg::*;

	// declared from the top bit down so that status lands in the lowest bits
	typedef struct packed {
		logic [31:0] sample_count;
		logic [31:0] data_size;
		logic [31:0] file_size;
		logic [2:0]  sample_format;
		logic [15:0] bits_per_sample;
		logic [15:0] block_align;
		logic [31:0] byte_rate;
		logic [31:0] sample_rate;
		logic [15:0] channel_count;
		logic [15:0] format_tag;
		logic        container;
		logic [1:0]  status;
	} hdr_info_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [231:0] m_tdata;

	wav_aiff_header_parser DUT (.*);

	always #10 clk = ~clk;

	// parser mirror state
	logic [3:0]  ph;
	logic [4:0]  bidx;
	logic [31:0] asm_w, ctag, skip_left;
	logic        aiff;
	hdr_info_t   cap;

	hdr_info_t   hdr_q[$];
	int          errors = 0;
	int          n_words = 0, n_results = 0, n_ok = 0;
	bit          hold_off = 0;
	bit          drv_on = 0;
	logic [7:0]  stream[$];

	function automatic logic [2:0] bits_code(input logic [15:0] b);
		if (b <= 16'd8) return 3'd1;
		if (b <= 16'd16) return 3'd2;
		if (b <= 16'd24) return 3'd3;
		if (b <= 16'd32) return 3'd4;
		return 3'd0;
	endfunction

	task automatic mirror_clear();
		ph = PH_SIG; bidx = '0; asm_w = '0; ctag = '0; skip_left = '0; aiff = 1'b0;
		cap = '0;
	endtask

	task automatic push_error(input logic [1:0] code);
		hdr_info_t r;
		r = '0; r.status = code; r.container = aiff;
		hdr_q.push_back(r); ph = PH_DONE;
	endtask

	task automatic push_ok();
		hdr_info_t r;
		r = cap; r.status = ST_OK; r.container = aiff;
		hdr_q.push_back(r); ph = PH_DONE;
	endtask

	// advance the mirror by one accepted word
	task automatic predict_word(input logic [7:0] b, input logic eos);
		logic [31:0] n;
		logic [15:0] lh;
		if (eos) begin
			if (ph != PH_DONE) push_error(ST_EARLY);
			mirror_clear();
			return;
		end
		if (ph == PH_DONE) return;
		bidx = bidx + 5'd1;
		if (ph inside {PH_SIG, PH_FTYPE, PH_CID, PH_COMM} ||
				(aiff && ph inside {PH_FSIZE, PH_CSIZE}))
			asm_w = {asm_w[23:0], b};
		else if (ph != PH_SKIP)
			asm_w = {b, asm_w[31:8]};
		case (ph)
			PH_SIG: if (bidx == 5'd4) begin
				if (asm_w == TAG_RIFF) aiff = 1'b0;
				else if (asm_w == TAG_FORM) aiff = 1'b1;
				else begin push_error(ST_SIG); return; end
				ph = PH_FSIZE; bidx = '0;
			end
			PH_FSIZE: if (bidx == 5'd4) begin
				if (asm_w == 32'd0) begin push_error(ST_ZERO); return; end
				cap.file_size = asm_w; ph = PH_FTYPE; bidx = '0;
			end
			PH_FTYPE: if (bidx == 5'd4) begin
				if (asm_w != (aiff ? TAG_AIFF : TAG_WAVE)) begin
					push_error(ST_SIG); return;
				end
				ph = PH_CID; bidx = '0;
			end
			PH_CID: if (bidx == 5'd4) begin ctag = asm_w; ph = PH_CSIZE; bidx = '0; end
			PH_CSIZE: if (bidx == 5'd4) begin
				n = asm_w; bidx = '0;
				if (n == 32'd0) begin push_error(ST_ZERO); return; end
				if (!aiff && ctag == TAG_FMT) ph = PH_FMT;
				else if (!aiff && ctag == TAG_DATA) begin
					cap.data_size = n;
					cap.sample_count = (cap.block_align != 16'd0) ?
						n / {16'd0, cap.block_align} : 32'd0;
					push_ok(); return;
				end else if (aiff && ctag == TAG_COMM) ph = PH_COMM;
				else if (aiff && ctag == TAG_SSND) begin
					cap.data_size = n; push_ok(); return;
				end else begin skip_left = n; ph = PH_SKIP; end
			end
			PH_FMT: case (bidx)
				5'd2: cap.format_tag = asm_w[31:16];
				5'd4: cap.channel_count = asm_w[31:16];
				5'd8: cap.sample_rate = asm_w;
				5'd12: cap.byte_rate = asm_w;
				5'd14: cap.block_align = asm_w[31:16];
				5'd16: begin
					cap.bits_per_sample = asm_w[31:16];
					cap.sample_format = bits_code(asm_w[31:16]);
					ph = (cap.format_tag != 16'd1) ? PH_XLEN : PH_CID; bidx = '0;
				end
				default: ;
			endcase
			PH_XLEN: if (bidx == 5'd2) begin
				n = {16'd0, asm_w[31:16]}; bidx = '0;
				if (n == 32'd0) ph = PH_CID;
				else begin skip_left = n; ph = PH_SKIP; end
			end
			PH_COMM: begin
				lh = asm_w[15:0];
				case (bidx)
					5'd2: cap.channel_count = lh;
					5'd6: cap.sample_count = asm_w;
					5'd8: begin cap.bits_per_sample = lh; cap.sample_format = bits_code(lh); end
					5'd12: cap.sample_rate = (asm_w == RATE_11K) ? 32'd11025 :
						(asm_w == RATE_22K) ? 32'd22050 : 32'd44100;
					5'd18: begin ph = PH_CID; bidx = '0; end
					default: ;
				endcase
			end
			PH_SKIP: begin
				if (skip_left > 32'd0) skip_left--;
				if (skip_left == 32'd0) begin ph = PH_CID; bidx = '0; end
			end
			default: mirror_clear();
		endcase
	endtask

	// drop valid, at most once per time step
	task automatic send_idle();
		if (drv_on) begin
			s_tvalid <= 1'b0;
			drv_on = 1'b0;
		end
	endtask

	// send one word; sender bursts with random gaps
	int burst_left = 0;
	task automatic send_word(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
			if (gap > 0) begin
				send_idle();
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1; s_tdata <= b; s_tlast <= eos;
		drv_on = 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_word(b, eos);
		n_words++;
	endtask

	task automatic flush_stream();
		while (stream.size()) send_word(stream.pop_front(), 1'b0);
	endtask

	task automatic put32(input logic [31:0] v, input bit big);
		for (int i = 0; i < 4; i++)
			stream.push_back(big ? v[31 - 8*i -: 8] : v[8*i +: 8]);
	endtask

	task automatic put16(input logic [15:0] v, input bit big);
		if (big) begin stream.push_back(v[15:8]); stream.push_back(v[7:0]); end
		else begin stream.push_back(v[7:0]); stream.push_back(v[15:8]); end
	endtask

	task automatic put_fmt(input logic [15:0] ftag, input logic [15:0] bits,
			input logic [15:0] align, input logic [15:0] xlen);
		put32(TAG_FMT, 1); put32(32'($urandom_range(1, 40)), 0);
		put16(ftag, 0); put16(16'($urandom), 0); put32($urandom, 0); put32($urandom, 0);
		put16(align, 0); put16(bits, 0);
		if (ftag != 16'd1) begin
			put16(xlen, 0);
			repeat (xlen) stream.push_back(8'($urandom));
		end
	endtask

	task automatic put_comm(input logic [31:0] rate, input logic [15:0] bits);
		put32(TAG_COMM, 1); put32(32'd18, 1);
		put16(16'($urandom), 1); put32($urandom, 1); put16(bits, 1); put32(rate, 1);
		repeat (6) stream.push_back(8'($urandom));
	endtask

	task automatic put_junk(input bit big);
		int n;
		n = $urandom_range(1, 12);
		put32($urandom, 1); put32(32'(n), big);
		repeat (n) stream.push_back(8'($urandom));
	endtask

	function automatic logic [15:0] rand_bits();
		case ($urandom_range(0, 5))
			0: return 16'd8; 1: return 16'd16; 2: return 16'd24; 3: return 16'd32;
			4: return 16'($urandom_range(33, 70)); default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_align();
		case ($urandom_range(0, 4))
			0: return 16'd0; 1: return 16'hFFFF; 2: return 16'd1;
			default: return 16'($urandom_range(1, 16));
		endcase
	endfunction

	// one well-formed header with random content, optionally corrupted
	task automatic put_header(input bit big, input bit corrupt);
		int k;
		if (big) begin put32(TAG_FORM, 1); put32($urandom | 1, 1); put32(TAG_AIFF, 1); end
		else begin put32(TAG_RIFF, 1); put32($urandom | 1, 0); put32(TAG_WAVE, 1); end
		k = $urandom_range(0, 2);
		repeat (k) begin
			if ($urandom_range(0, 2) == 0) put_junk(big);
			else if (big) put_comm($urandom_range(0, 1) ? RATE_11K :
				$urandom_range(0, 1) ? RATE_22K : $urandom, rand_bits());
			else put_fmt($urandom_range(0, 2) ? 16'd1 : 16'($urandom), rand_bits(),
				rand_align(), $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 6)));
		end
		put32(big ? TAG_SSND : TAG_DATA, 1);
		put32($urandom_range(0, 7) == 0 ? 32'hFFFFFFFF : $urandom | 1, big);
		if (corrupt) begin
			k = $urandom_range(0, stream.size() - 1);
			case ($urandom_range(0, 2))
				0: stream[k] = 8'($urandom);
				1: begin
					// cut the stream early
					while (stream.size() > k) void'(stream.pop_back());
					flush_stream(); send_word(8'($urandom), 1'b1); return;
				end
				default: if (k >= 4 && k <= 7) for (int i = 4; i < 8; i++) stream[i] = 8'd0;
			endcase
		end
		flush_stream();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) send_word(8'($urandom), 1'b0);
		send_word(8'($urandom), 1'b1);
	endtask

	task automatic wait_drain();
		int guard;
		guard = 0;
		send_idle();
		while (hdr_q.size() && guard < 20000) begin @(posedge clk); guard++; end
		repeat (40) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [31:0] rates[3];
		rates[0] = RATE_11K; rates[1] = RATE_22K; rates[2] = 32'h400EAC44;
		send_word(8'h00, 1'b1);                       // empty stream
		put32(32'h00FF00FF, 1); flush_stream(); send_word(8'h00, 1'b1);  // bad signature
		put32(TAG_RIFF, 1); put32(32'd0, 0); flush_stream(); send_word(8'h00, 1'b1);
		put32(TAG_FORM, 1); put16(16'h1234, 1); flush_stream(); send_word(8'hFF, 1'b1);
		put32(TAG_RIFF, 1); put32(32'd36, 0); put32(TAG_AIFF, 1); flush_stream();
		send_word(8'h00, 1'b1);
		put32(TAG_RIFF, 1); put32(32'hFFFFFFFF, 0); put32(TAG_WAVE, 1);
		put_fmt(16'd1, 16'd16, 16'd4, 16'd0); put_junk(0); put32(TAG_DATA, 1);
		put32(32'hFFFFFFFF, 0);
		flush_stream(); send_word(8'hAA, 1'b0); send_word(8'h00, 1'b1);
		put32(TAG_RIFF, 1); put32(32'd1, 0); put32(TAG_WAVE, 1);
		put_fmt(16'hFFFE, 16'hFFFF, 16'd0, 16'd3); put32(TAG_COMM, 1); put32(32'd2, 0);
		stream.push_back(8'hFF); stream.push_back(8'h00);
		put32(TAG_DATA, 1); put32(32'd0, 0); flush_stream(); send_word(8'h00, 1'b1);
		for (int i = 0; i < 3; i++) begin
			put32(TAG_FORM, 1); put32(32'd100, 1); put32(TAG_AIFF, 1);
			put_comm(rates[i], 16'd0);
			put32(TAG_FMT, 1); put32(32'd1, 1); stream.push_back(8'h00);
			put32(TAG_SSND, 1); put32(32'd8, 1); flush_stream(); send_word(8'h00, 1'b1);
		end
		wait_drain();
	endtask

	task automatic test_random_streams();
		while (n_words < 1600) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					send_word(8'($urandom), $urandom_range(0, 7) == 0);
			end else put_header($urandom_range(0, 1), $urandom_range(0, 4) == 0);
		end
	endtask

	task automatic test_backpressure();
		// receiver holds off while headers keep arriving
		fork
			begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
			begin
				repeat (3) put_header($urandom_range(0, 1), 0);
				send_idle();
			end
		join
		wait_drain();   // sender pauses until every result has come
	endtask

	// receiver stall pattern
	int rx_phase = 0;
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		m_tready <= !hold_off && (rx_phase[8] ? 1'b1 : ($urandom_range(0, 2) != 0));
	end

	task automatic chk_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (a !== e) begin
			$error("%s exp %0h got %0h", name, e, a);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		hdr_info_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = hdr_info_t'(m_tdata[229:0]);
			n_results++;
			if (hdr_q.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata); errors++;
			end else begin
				exp_r = hdr_q.pop_front();
				if (got.status == ST_OK) n_ok++;
				chk_field("status", 32'(exp_r.status), 32'(got.status));
				chk_field("container", 32'(exp_r.container), 32'(got.container));
				chk_field("format_tag", 32'(exp_r.format_tag), 32'(got.format_tag));
				chk_field("channel_count", 32'(exp_r.channel_count),
					32'(got.channel_count));
				chk_field("sample_rate", exp_r.sample_rate, got.sample_rate);
				chk_field("byte_rate", exp_r.byte_rate, got.byte_rate);
				chk_field("block_align", 32'(exp_r.block_align), 32'(got.block_align));
				chk_field("bits_per_sample", 32'(exp_r.bits_per_sample),
					32'(got.bits_per_sample));
				chk_field("sample_format", 32'(exp_r.sample_format),
					32'(got.sample_format));
				chk_field("file_size", exp_r.file_size, got.file_size);
				chk_field("data_size", exp_r.data_size, got.data_size);
				chk_field("sample_count", exp_r.sample_count, got.sample_count);
			end
		end
	end

	initial begin
		mirror_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_backpressure();
		test_random_streams();
		wait_drain();
		$display("Covered %0d input words, %0d results (%0d good headers).",
			n_words, n_results, n_ok);
		if (errors == 0 && hdr_q.size() == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(20ns * 400000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/wahp_pkg.sv
sv/wahp_div.sv
sv/wahp_datapath.sv
sv/wahp_ctrl.sv
sv/wav_aiff_header_parser.sv
tb/sv/tb_top.sv
